@@ design/sqlkw_pkg.sv @@
package sqlkw_pkg;

	localparam int KEYWORD_MAX = 9;
	localparam int OFFSET_BITS = 32;
	localparam int LENGTH_BITS = 16;
	localparam int KIND_W = 6;
	localparam int BYTE_W = 8;
	localparam int PIDX_W = $clog2(KEYWORD_MAX);
	localparam int IN_DATA_W = ((BYTE_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = KIND_W + OFFSET_BITS + LENGTH_BITS + 1;
	localparam int OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	localparam logic [KIND_W-1:0] K_IDENT = 6'd0;
	localparam logic [KIND_W-1:0] K_INT = 6'd1;
	localparam logic [KIND_W-1:0] K_FLOAT = 6'd2;
	localparam logic [KIND_W-1:0] K_STR = 6'd3;
	localparam logic [KIND_W-1:0] K_LPAREN = 6'd4;
	localparam logic [KIND_W-1:0] K_RPAREN = 6'd5;
	localparam logic [KIND_W-1:0] K_COMMA = 6'd6;
	localparam logic [KIND_W-1:0] K_EQ = 6'd7;
	localparam logic [KIND_W-1:0] K_LT = 6'd8;
	localparam logic [KIND_W-1:0] K_LE = 6'd9;
	localparam logic [KIND_W-1:0] K_NE = 6'd10;
	localparam logic [KIND_W-1:0] K_GT = 6'd11;
	localparam logic [KIND_W-1:0] K_GE = 6'd12;
	localparam logic [KIND_W-1:0] K_PLUS = 6'd13;
	localparam logic [KIND_W-1:0] K_MINUS = 6'd14;
	localparam logic [KIND_W-1:0] K_STAR = 6'd15;
	localparam logic [KIND_W-1:0] K_SLASH = 6'd16;
	localparam logic [KIND_W-1:0] K_SEMI = 6'd17;
	localparam logic [KIND_W-1:0] K_BAD = 6'd18;
	localparam int K_KW0 = 19;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_E = 8'h65;

	localparam int KW_COUNT = 38;
	localparam logic [8*KEYWORD_MAX-1:0] KW_TEXT [KW_COUNT] = '{
		"and", "bool", "by", "close", "create", "connect", "drop", "desc",
		"delete", "describe", "database", "databases", "distinct", "exit",
		"exists", "float", "false", "from", "int", "into", "insert", "if", "is",
		"null", "not", "open", "or", "order", "string", "select", "set", "show",
		"true", "table", "tables", "update", "values", "where"
	};
	localparam int KW_LEN [KW_COUNT] = '{
		3, 4, 2, 5, 6, 7, 4, 4,
		6, 8, 8, 9, 8, 4,
		6, 5, 5, 4, 3, 4, 6, 2, 2,
		4, 3, 4, 2, 5, 6, 6, 3, 4,
		4, 5, 6, 6, 6, 5
	};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] length;
		logic last;
	} res_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic [KIND_W-1:0] kw_lookup(
		input logic [KEYWORD_MAX-1:0][7:0] pref,
		input logic [LENGTH_BITS-1:0] len
	);
		logic [KIND_W-1:0] kind;
		logic same;
		kind = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			same = (len == LENGTH_BITS'(KW_LEN[i]));
			for (int j = 0; j < KW_LEN[i]; j++) begin
				if (pref[j] != KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				kind = KIND_W'(K_KW0 + i);
			end
		end
		return kind;
	endfunction

endpackage

@@ design/sql_keyword_lexer_top.sv @@
// Channel   Direction  Payload (tdata from bit 0 up)                    tlast
// s_axis    in         text_byte                                        end_of_text
// m_axis    out        token_kind, token_start, token_length, is_error  last_of_run
//
// A byte is registered on acceptance and lexed from that register, which writes up to two
// tokens into a four-entry result queue. One byte per cycle is sustained while the queue
// has room for two tokens; the one-token-per-cycle output drain sets the limit otherwise.
// Reset clears the scanner state, the byte offset and the queue.
// A stalled output backs up the queue first, then the input register.
module sql_keyword_lexer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [sqlkw_pkg::IN_DATA_W-1:0] s_axis_tdata,  // text_byte
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// token_kind, token_start, token_length, is_error
	output logic [sqlkw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);

	typedef enum logic [2:0] {
		M_IDLE, M_NUM, M_STR, M_WORD, M_BAD, M_LT, M_GT
	} mode_t;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	mode_t mode_q, mode_n, mode_b;
	logic [sqlkw_pkg::OFFSET_BITS-1:0] start_q, start_n;
	logic [sqlkw_pkg::LENGTH_BITS-1:0] len_q, len_n, len_grow;
	logic point_q, point_n;
	logic [sqlkw_pkg::KEYWORD_MAX-1:0][7:0] pref_q, pref_n;
	logic [sqlkw_pkg::OFFSET_BITS-1:0] pos_q, pos_n;

	sqlkw_pkg::res_t fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0] count_q;

	logic adv, pop, taken;
	logic e1v, e2v, e3v;
	logic [sqlkw_pkg::KIND_W-1:0] e1_kind, e2_kind, e3_kind, kw_old_kind, kw_new_kind;
	logic [sqlkw_pkg::OFFSET_BITS-1:0] e1_start, e2_start, e3_start;
	logic [sqlkw_pkg::LENGTH_BITS-1:0] e1_len, e2_len, e3_len;
	sqlkw_pkg::res_t res0, res1;
	logic [1:0] push_n;
	sqlkw_pkg::res_t head;

	assign adv = valid_s1 && (count_q <= (PTR_W+1)'(FIFO_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || adv;
	assign pop = m_axis_tvalid && m_axis_tready;
	assign len_grow = (len_q == sqlkw_pkg::LEN_MAX) ? len_q : len_q + 1'b1;

	assign kw_old_kind = sqlkw_pkg::kw_lookup(pref_q, len_q);
	assign kw_new_kind = sqlkw_pkg::kw_lookup(pref_n, len_n);

	always_comb begin
		mode_b = mode_q;
		start_n = start_q;
		len_n = len_q;
		point_n = point_q;
		pref_n = pref_q;
		taken = 1'b1;
		e1v = 1'b0;
		e1_kind = sqlkw_pkg::K_IDENT;
		e1_start = start_q;
		e1_len = len_q;
		e2v = 1'b0;
		e2_kind = sqlkw_pkg::K_IDENT;
		e2_start = pos_q;
		e2_len = sqlkw_pkg::LENGTH_BITS'(1);

		case (mode_q)
			M_NUM: begin
				if (sqlkw_pkg::is_digit(byte_s1) || byte_s1 == sqlkw_pkg::CH_DOT
						|| byte_s1 == sqlkw_pkg::CH_E || byte_s1 == sqlkw_pkg::CH_MINUS) begin
					if (byte_s1 == sqlkw_pkg::CH_DOT) begin
						point_n = 1'b1;
					end
					len_n = len_grow;
				end else begin
					e1v = 1'b1;
					e1_kind = point_q ? sqlkw_pkg::K_FLOAT : sqlkw_pkg::K_INT;
					taken = 1'b0;
				end
			end
			M_STR: begin
				if (byte_s1 == sqlkw_pkg::CH_QUOTE) begin
					e1v = 1'b1;
					e1_kind = sqlkw_pkg::K_STR;
					mode_b = M_IDLE;
				end else begin
					len_n = len_grow;
				end
			end
			M_WORD: begin
				if (sqlkw_pkg::is_letter(byte_s1) || sqlkw_pkg::is_digit(byte_s1)
						|| byte_s1 == sqlkw_pkg::CH_UNDERSCORE) begin
					if (len_q < sqlkw_pkg::LENGTH_BITS'(sqlkw_pkg::KEYWORD_MAX)) begin
						pref_n[len_q[sqlkw_pkg::PIDX_W-1:0]] = byte_s1;
					end
					len_n = len_grow;
				end else begin
					e1v = 1'b1;
					e1_kind = kw_old_kind;
					taken = 1'b0;
				end
			end
			M_BAD: begin
				if (sqlkw_pkg::is_space(byte_s1) || byte_s1 == sqlkw_pkg::CH_SEMI) begin
					e1v = 1'b1;
					e1_kind = sqlkw_pkg::K_BAD;
					taken = 1'b0;
				end else begin
					len_n = len_grow;
				end
			end
			M_LT: begin
				e1v = 1'b1;
				if (byte_s1 == sqlkw_pkg::CH_EQ || byte_s1 == sqlkw_pkg::CH_GT) begin
					e1_kind = (byte_s1 == sqlkw_pkg::CH_EQ) ? sqlkw_pkg::K_LE : sqlkw_pkg::K_NE;
					e1_len = sqlkw_pkg::LENGTH_BITS'(2);
					mode_b = M_IDLE;
				end else begin
					e1_kind = sqlkw_pkg::K_LT;
					e1_len = sqlkw_pkg::LENGTH_BITS'(1);
					taken = 1'b0;
				end
			end
			M_GT: begin
				e1v = 1'b1;
				if (byte_s1 == sqlkw_pkg::CH_EQ) begin
					e1_kind = sqlkw_pkg::K_GE;
					e1_len = sqlkw_pkg::LENGTH_BITS'(2);
					mode_b = M_IDLE;
				end else begin
					e1_kind = sqlkw_pkg::K_GT;
					e1_len = sqlkw_pkg::LENGTH_BITS'(1);
					taken = 1'b0;
				end
			end
			default: begin
				taken = 1'b0;
			end
		endcase

		if (!taken) begin
			start_n = pos_q;
			len_n = sqlkw_pkg::LENGTH_BITS'(1);
			point_n = 1'b0;
			mode_b = M_IDLE;
			case (byte_s1)
				sqlkw_pkg::CH_SPACE, sqlkw_pkg::CH_TAB, sqlkw_pkg::CH_NL: begin
					mode_b = M_IDLE;
				end
				sqlkw_pkg::CH_LPAREN: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_LPAREN;
				end
				sqlkw_pkg::CH_RPAREN: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_RPAREN;
				end
				sqlkw_pkg::CH_COMMA: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_COMMA;
				end
				sqlkw_pkg::CH_EQ: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_EQ;
				end
				sqlkw_pkg::CH_PLUS: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_PLUS;
				end
				sqlkw_pkg::CH_MINUS: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_MINUS;
				end
				sqlkw_pkg::CH_STAR: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_STAR;
				end
				sqlkw_pkg::CH_SLASH: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_SLASH;
				end
				sqlkw_pkg::CH_SEMI: begin
					e2v = 1'b1;
					e2_kind = sqlkw_pkg::K_SEMI;
				end
				sqlkw_pkg::CH_LT: begin
					mode_b = M_LT;
				end
				sqlkw_pkg::CH_GT: begin
					mode_b = M_GT;
				end
				sqlkw_pkg::CH_QUOTE: begin
					mode_b = M_STR;
					start_n = pos_q + 1'b1;
					len_n = '0;
				end
				default: begin
					if (sqlkw_pkg::is_digit(byte_s1) || byte_s1 == sqlkw_pkg::CH_DOT) begin
						mode_b = M_NUM;
						point_n = (byte_s1 == sqlkw_pkg::CH_DOT);
					end else if (sqlkw_pkg::is_letter(byte_s1)
							|| byte_s1 == sqlkw_pkg::CH_UNDERSCORE) begin
						mode_b = M_WORD;
						pref_n[0] = byte_s1;
					end else begin
						mode_b = M_BAD;
					end
				end
			endcase
		end
	end

	always_comb begin
		e3v = 1'b0;
		e3_kind = sqlkw_pkg::K_IDENT;
		e3_start = start_n;
		e3_len = len_n;
		mode_n = mode_b;
		pos_n = pos_q + 1'b1;
		if (last_s1) begin
			mode_n = M_IDLE;
			pos_n = '0;
			e3v = (mode_b != M_IDLE);
			case (mode_b)
				M_NUM: e3_kind = point_n ? sqlkw_pkg::K_FLOAT : sqlkw_pkg::K_INT;
				M_STR: e3_kind = sqlkw_pkg::K_STR;
				M_WORD: e3_kind = kw_new_kind;
				M_BAD: e3_kind = sqlkw_pkg::K_BAD;
				M_LT: begin
					e3_kind = sqlkw_pkg::K_LT;
					e3_len = sqlkw_pkg::LENGTH_BITS'(1);
				end
				M_GT: begin
					e3_kind = sqlkw_pkg::K_GT;
					e3_len = sqlkw_pkg::LENGTH_BITS'(1);
				end
				default: e3v = 1'b0;
			endcase
		end
	end

	always_comb begin
		push_n = 2'(e1v) + 2'(e2v) + 2'(e3v);
		if (e1v) begin
			res0 = '{kind: e1_kind, start: e1_start, length: e1_len, last: 1'b0};
		end else if (e2v) begin
			res0 = '{kind: e2_kind, start: e2_start, length: e2_len, last: 1'b0};
		end else begin
			res0 = '{kind: e3_kind, start: e3_start, length: e3_len, last: 1'b0};
		end
		if (e1v && e2v) begin
			res1 = '{kind: e2_kind, start: e2_start, length: e2_len, last: 1'b1};
		end else begin
			res1 = '{kind: e3_kind, start: e3_start, length: e3_len, last: 1'b1};
		end
		res0.last = (push_n == 2'd1);
	end

	assign head = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tlast = head.last;
	assign m_axis_tdata = sqlkw_pkg::OUT_DATA_W'({head.kind == sqlkw_pkg::K_BAD,
		head.length, head.start, head.kind});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= M_IDLE;
			start_q <= '0;
			len_q <= '0;
			point_q <= 1'b0;
			pos_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				mode_q <= mode_n;
				start_q <= start_n;
				len_q <= len_n;
				point_q <= point_n;
				pos_q <= pos_n;
				wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (adv ? (PTR_W+1)'(push_n) : '0) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
		if (adv) begin
			pref_q <= pref_n;
			if (push_n != 2'd0) begin
				fifo_q[wr_ptr_q] <= res0;
			end
			if (push_n == 2'd2) begin
				fifo_q[wr_ptr_q + 1'b1] <= res1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(adv || pop) |=> count_q == $past(count_q)
			+ ($past(adv) ? (PTR_W+1)'($past(push_n)) : '0) - (PTR_W+1)'($past(pop)))
		else $error("result queue count out of step with pushes and pops");

	a_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (mode_q == M_IDLE) && (pos_q == '0))
		else $error("end of text did not return the scanner to idle");
`endif

endmodule

@@ bench/sqlkw_token_checker.sv @@
`timescale 1ns / 100ps

module sqlkw_token_checker
	import sqlkw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	input  logic s_axis_tlast,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic m_axis_tlast,
	output int mismatches,
	output int pending,
	output int tokens_checked,
	output int keywords_checked,
	output int bad_runs_checked
);

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_NUM, SCAN_STR, SCAN_WORD, SCAN_BAD, SCAN_LT, SCAN_GT
	} scan_e;

	typedef struct packed {
		logic [OUT_DATA_W-OUT_FIELD_W-1:0] pad;
		logic is_error;
		logic [LENGTH_BITS-1:0] length;
		logic [OFFSET_BITS-1:0] start;
		logic [KIND_W-1:0] kind;
	} beat_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] length;
		logic is_error;
		logic last;
	} token_t;

	string keyword_names [KW_COUNT] = '{
		"and", "bool", "by", "close", "create", "connect", "drop", "desc",
		"delete", "describe", "database", "databases", "distinct", "exit",
		"exists", "float", "false", "from", "int", "into", "insert", "if", "is",
		"null", "not", "open", "or", "order", "string", "select", "set", "show",
		"true", "table", "tables", "update", "values", "where"
	};

	scan_e mode = SCAN_IDLE;
	logic [OFFSET_BITS-1:0] tok_start = '0;
	logic [OFFSET_BITS-1:0] position = '0;
	logic [LENGTH_BITS-1:0] tok_len = '0;
	logic saw_dot = 1'b0;
	logic [7:0] word_chars [KEYWORD_MAX];
	token_t tokens_due [$];
	token_t step_tokens [$];

	function automatic bit digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter_char(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit blank_char(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_NL;
	endfunction

	function automatic void add_token(input logic [KIND_W-1:0] kind,
			input logic [OFFSET_BITS-1:0] origin, input logic [LENGTH_BITS-1:0] span);
		token_t t;
		t.kind = kind;
		t.start = origin;
		t.length = span;
		t.is_error = (kind == K_BAD);
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void lengthen();
		if (tok_len != LEN_MAX) begin
			tok_len++;
		end
	endfunction

	// A word is a keyword only when it is short enough to be held whole and matches exactly.
	function automatic logic [KIND_W-1:0] word_kind();
		bit hit;
		if (tok_len > KEYWORD_MAX) begin
			return K_IDENT;
		end
		for (int i = 0; i < KW_COUNT; i++) begin
			hit = (keyword_names[i].len() == int'(tok_len));
			for (int j = 0; hit && j < keyword_names[i].len(); j++) begin
				hit = (word_chars[j] == keyword_names[i][j]);
			end
			if (hit) begin
				return KIND_W'(K_KW0 + i);
			end
		end
		return K_IDENT;
	endfunction

	function automatic void close_token();
		case (mode)
			SCAN_NUM: add_token(saw_dot ? K_FLOAT : K_INT, tok_start, tok_len);
			SCAN_STR: add_token(K_STR, tok_start, tok_len);
			SCAN_WORD: add_token(word_kind(), tok_start, tok_len);
			SCAN_BAD: add_token(K_BAD, tok_start, tok_len);
			SCAN_LT: add_token(K_LT, tok_start, LENGTH_BITS'(1));
			SCAN_GT: add_token(K_GT, tok_start, LENGTH_BITS'(1));
			default: ;
		endcase
		mode = SCAN_IDLE;
	endfunction

	function automatic void open_token(input logic [7:0] c, input logic [OFFSET_BITS-1:0] p);
		mode = SCAN_IDLE;
		tok_start = p;
		tok_len = LENGTH_BITS'(1);
		saw_dot = 1'b0;
		case (c)
			CH_SPACE, CH_TAB, CH_NL: ;
			CH_LPAREN: add_token(K_LPAREN, p, LENGTH_BITS'(1));
			CH_RPAREN: add_token(K_RPAREN, p, LENGTH_BITS'(1));
			CH_COMMA: add_token(K_COMMA, p, LENGTH_BITS'(1));
			CH_EQ: add_token(K_EQ, p, LENGTH_BITS'(1));
			CH_PLUS: add_token(K_PLUS, p, LENGTH_BITS'(1));
			CH_MINUS: add_token(K_MINUS, p, LENGTH_BITS'(1));
			CH_STAR: add_token(K_STAR, p, LENGTH_BITS'(1));
			CH_SLASH: add_token(K_SLASH, p, LENGTH_BITS'(1));
			CH_SEMI: add_token(K_SEMI, p, LENGTH_BITS'(1));
			CH_LT: mode = SCAN_LT;
			CH_GT: mode = SCAN_GT;
			CH_QUOTE: begin
				mode = SCAN_STR;
				tok_start = p + 1'b1;
				tok_len = '0;
			end
			default: begin
				if (digit_char(c) || c == CH_DOT) begin
					mode = SCAN_NUM;
					saw_dot = (c == CH_DOT);
				end else if (letter_char(c) || c == CH_UNDERSCORE) begin
					mode = SCAN_WORD;
					word_chars[0] = c;
				end else begin
					mode = SCAN_BAD;
				end
			end
		endcase
	endfunction

	// A byte that cannot continue the open token closes it and then opens the next one.
	function automatic void lex_byte(input logic [7:0] c, input logic eot);
		logic [OFFSET_BITS-1:0] p;
		bit consumed;
		p = position;
		consumed = 1'b1;
		step_tokens.delete();
		case (mode)
			SCAN_NUM: begin
				if (digit_char(c) || c == CH_DOT || c == CH_E || c == CH_MINUS) begin
					if (c == CH_DOT) begin
						saw_dot = 1'b1;
					end
					lengthen();
				end else begin
					close_token();
					consumed = 1'b0;
				end
			end
			SCAN_STR: begin
				if (c == CH_QUOTE) begin
					add_token(K_STR, tok_start, tok_len);
					mode = SCAN_IDLE;
				end else begin
					lengthen();
				end
			end
			SCAN_WORD: begin
				if (letter_char(c) || digit_char(c) || c == CH_UNDERSCORE) begin
					if (tok_len < KEYWORD_MAX) begin
						word_chars[tok_len[PIDX_W-1:0]] = c;
					end
					lengthen();
				end else begin
					close_token();
					consumed = 1'b0;
				end
			end
			SCAN_BAD: begin
				if (blank_char(c) || c == CH_SEMI) begin
					close_token();
					consumed = 1'b0;
				end else begin
					lengthen();
				end
			end
			SCAN_LT: begin
				if (c == CH_EQ || c == CH_GT) begin
					add_token(c == CH_EQ ? K_LE : K_NE, tok_start, LENGTH_BITS'(2));
					mode = SCAN_IDLE;
				end else begin
					close_token();
					consumed = 1'b0;
				end
			end
			SCAN_GT: begin
				if (c == CH_EQ) begin
					add_token(K_GE, tok_start, LENGTH_BITS'(2));
					mode = SCAN_IDLE;
				end else begin
					close_token();
					consumed = 1'b0;
				end
			end
			default: consumed = 1'b0;
		endcase
		if (!consumed) begin
			open_token(c, p);
		end
		if (eot) begin
			close_token();
			position = '0;
		end else begin
			position = p + 1'b1;
		end
		if (step_tokens.size() > 0) begin
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		end
		foreach (step_tokens[i]) begin
			tokens_due.push_back(step_tokens[i]);
		end
	endfunction

	function automatic string describe_token(input token_t t);
		return $sformatf("kind %0d start %0d length %0d error %0b last %0b",
			t.kind, t.start, t.length, t.is_error, t.last);
	endfunction

	function automatic void check_token();
		beat_t beat;
		token_t got;
		token_t want;
		beat = m_axis_tdata;
		got.kind = beat.kind;
		got.start = beat.start;
		got.length = beat.length;
		got.is_error = beat.is_error;
		got.last = m_axis_tlast;
		tokens_checked++;
		if (tokens_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 40) begin
				$display("%0t: unexpected token: expected none, actual %s",
					$realtime, describe_token(got));
			end
		end else begin
			want = tokens_due.pop_front();
			if (want.kind >= K_KW0) begin
				keywords_checked++;
			end
			if (want.is_error) begin
				bad_runs_checked++;
			end
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 40) begin
					$display("%0t: token mismatch: expected %s, actual %s",
						$realtime, describe_token(want), describe_token(got));
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = SCAN_IDLE;
			tok_start = '0;
			tok_len = '0;
			saw_dot = 1'b0;
			position = '0;
			tokens_due.delete();
			pending <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				lex_byte(s_axis_tdata[7:0], s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				check_token();
			end
			pending <= tokens_due.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import sqlkw_pkg::*;

	localparam int CYCLE_LIMIT = 100_000;
	localparam int PHASE_BYTES = 300;
	localparam logic [7:0] OP_BYTES [11] = '{
		CH_LPAREN, CH_RPAREN, CH_COMMA, CH_EQ, CH_LT, CH_GT,
		CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_SEMI
	};

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	int mismatches;
	int pending;
	int tokens_checked;
	int keywords_checked;
	int bad_runs_checked;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_req = 0;
	int rx_hold_left = 0;
	int cycle_count = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	logic [7:0] text_bytes [$];

	sql_keyword_lexer_top uut (.*);

	sqlkw_token_checker token_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d tokens outstanding.",
				cycle_count, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// The receiver either holds off for a requested stretch or stalls at random.
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_req > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left <= rx_hold_req;
			rx_hold_req = 0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eot;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_bytes[i]) begin
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
		end
		text_bytes.delete();
		texts_sent++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			text_bytes.push_back(s[i]);
		end
	endtask

	task automatic wait_for_tokens();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic bit blank_byte(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_NL;
	endfunction

	function automatic bit opens_token(input logic [7:0] b);
		bit hit;
		hit = blank_byte(b) || b == CH_QUOTE || b == CH_DOT || b == CH_UNDERSCORE
			|| (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
		foreach (OP_BYTES[i]) begin
			hit |= (b == OP_BYTES[i]);
		end
		return hit;
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_NL;
		endcase
	endfunction

	function automatic logic [7:0] random_letter();
		if ($urandom_range(0, 3) == 0) begin
			return 8'($urandom_range("A", "Z"));
		end
		return 8'($urandom_range("a", "z"));
	endfunction

	task automatic append_token();
		int k;
		int n;
		int idx;
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0, 1: begin
				k = $urandom_range(0, KW_COUNT - 1);
				for (int j = 0; j < KW_LEN[k]; j++) begin
					text_bytes.push_back(KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 8]);
				end
				// Near misses: a trailing underscore, or a capital first letter.
				case ($urandom_range(0, 7))
					0: text_bytes.push_back(CH_UNDERSCORE);
					1: begin
						idx = text_bytes.size() - KW_LEN[k];
						text_bytes[idx] = text_bytes[idx] - 8'h20;
					end
					default: ;
				endcase
			end
			2: begin
				n = $urandom_range(1, 12);
				text_bytes.push_back($urandom_range(0, 5) == 0 ? CH_UNDERSCORE : random_letter());
				repeat (n - 1) begin
					case ($urandom_range(0, 5))
						0: text_bytes.push_back(8'($urandom_range("0", "9")));
						1: text_bytes.push_back(CH_UNDERSCORE);
						default: text_bytes.push_back(random_letter());
					endcase
				end
			end
			3: begin
				text_bytes.push_back($urandom_range(0, 3) == 0 ? CH_DOT
					: 8'($urandom_range("0", "9")));
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 9))
						0: text_bytes.push_back(CH_DOT);
						1: text_bytes.push_back(CH_E);
						2: text_bytes.push_back(CH_MINUS);
						default: text_bytes.push_back(8'($urandom_range("0", "9")));
					endcase
				end
			end
			4: begin
				text_bytes.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
					text_bytes.push_back(b);
				end
				if ($urandom_range(0, 7) != 0) begin
					text_bytes.push_back(CH_QUOTE);
				end
			end
			5, 6: begin
				k = $urandom_range(0, 13);
				case (k)
					11: queue_text("<=");
					12: queue_text("<>");
					13: queue_text(">=");
					default: text_bytes.push_back(OP_BYTES[k]);
				endcase
			end
			7: begin
				do b = 8'($urandom_range(1, 255)); while (opens_token(b));
				text_bytes.push_back(b);
				repeat ($urandom_range(0, 4)) begin
					do b = 8'($urandom_range(1, 255)); while (blank_byte(b) || b == CH_SEMI);
					text_bytes.push_back(b);
				end
			end
			default: begin
				repeat ($urandom_range(1, 2)) begin
					text_bytes.push_back(random_blank());
				end
			end
		endcase
	endtask

	task automatic build_statement();
		repeat ($urandom_range(1, 14)) begin
			append_token();
		end
		if ($urandom_range(0, 4) == 0) begin
			text_bytes.push_back(random_blank());
		end
	endtask

	initial begin
		int phase_first;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_text("<");
		send_text();
		queue_text(">");
		send_text();
		text_bytes.push_back(8'hFF);
		send_text();
		text_bytes.push_back(8'h01);
		text_bytes.push_back(CH_SPACE);
		send_text();
		queue_text("(),=<=<>>=+-*/;");
		send_text();
		queue_text("\"x");
		send_text();

		rx_hold_req = 300;
		while (text_bytes.size() < 60) begin
			append_token();
		end
		send_text();
		wait_for_tokens();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 62;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 62;
				end
				default: begin
					tx_idle_pct = 33;
					rx_stall_pct = 33;
				end
			endcase
			phase_first = bytes_sent;
			while (bytes_sent - phase_first < PHASE_BYTES) begin
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(1, 24)) begin
						text_bytes.push_back(8'($urandom_range(1, 255)));
					end
				end else begin
					build_statement();
				end
				send_text();
			end
		end

		wait_for_tokens();
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes in %0d texts under four idling mixes and a long output stall.",
			bytes_sent, texts_sent);
		$display("Checked %0d tokens: %0d keywords and %0d invalid runs.",
			tokens_checked, keywords_checked, bad_runs_checked);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
